// File: hdl/jump_ahead_queue_defines.svh
// Assertion macros used by the checker of the queue.
`ifndef JUMP_AHEAD_QUEUE_DEFINES_SVH
`define JUMP_AHEAD_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define JAQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("jump_ahead_queue check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define JAQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("jump_ahead_queue check failed");

`endif

// File: hdl/jaq_pkg.sv
package jaq_pkg;

	// Fixed field widths of the channels
	localparam int OP_W   = 2;
	localparam int VAL_W  = 32;
	localparam int HDL_W  = 6;
	localparam int DIST_W = 7;
	localparam int POS_W  = 6;
	localparam int CNT_W  = 7;
	localparam int ST_W   = 2;

	// Defaults for the top-level parameters
	localparam int CAPACITY_DEF  = 64;
	localparam int DATA_BITS_DEF = 32;

	// Operation codes
	localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
	localparam logic [OP_W-1:0] OP_POP   = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
	localparam logic [OP_W-1:0] OP_JUMP  = 2'd3;

	// Status codes
	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY   = 2'd2;
	localparam logic [ST_W-1:0] ST_UNKNOWN = 2'd3;

	// Broadcast control from the sequencer to every cell
	typedef struct packed {
		logic load;	// capture handle match at command transfer
		logic push;	// write tail cell
		logic pop;	// shift towards head
		logic jump;	// rotate the span np..pos
	} cell_ctl_t;

endpackage

// File: hdl/jaq_cmd_if.sv
interface jaq_cmd_if;
	logic                                valid;
	logic                                ready;
	logic        [jaq_pkg::OP_W-1:0]     op;
	logic signed [jaq_pkg::VAL_W-1:0]    push_value;
	logic        [jaq_pkg::HDL_W-1:0]    handle_in;
	logic        [jaq_pkg::DIST_W-1:0]   jump_distance;

	modport source (output valid, op, push_value, handle_in, jump_distance, input ready);
	modport sink   (input valid, op, push_value, handle_in, jump_distance, output ready);
endinterface

// File: hdl/jaq_res_if.sv
interface jaq_res_if;
	logic                               valid;
	logic                               ready;
	logic        [jaq_pkg::ST_W-1:0]    status;
	logic signed [jaq_pkg::VAL_W-1:0]   value_out;
	logic        [jaq_pkg::HDL_W-1:0]   handle_out;
	logic        [jaq_pkg::POS_W-1:0]   position_out;
	logic        [jaq_pkg::CNT_W-1:0]   count_out;

	modport source (output valid, status, value_out, handle_out, position_out, count_out,
		input ready);
	modport sink   (input valid, status, value_out, handle_out, position_out, count_out,
		output ready);
endinterface

// File: hdl/jump_ahead_queue.sv
// Ordered queue of up to CAPACITY values, each tagged with a handle (the lowest free one
// at push). Each command passes an idle and an execute state: at the command transfer each
// cell of the slot chain compares its handle and the lowest free handle is found; in the
// execute state the position is encoded and all cells shift towards the head (pop), the span
// np..pos rotates (jump) or the tail cell is written (push), and the result is loaded into the
// output register. A new command is taken only once the execute state is done, while the result
// may still wait; the execute state holds only when the output register is still occupied.
module jump_ahead_queue #(
	parameter int CAPACITY  = jaq_pkg::CAPACITY_DEF,
	parameter int DATA_BITS = jaq_pkg::DATA_BITS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	jaq_cmd_if.sink  cmd,
	jaq_res_if.source res
);

	localparam int HW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (HW > jaq_pkg::DIST_W) ? HW : jaq_pkg::DIST_W;
	localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic                    state_q;
	logic [CW-1:0]           count_q;
	logic [CAPACITY-1:0]     used_q;

	// command captured at transfer
	logic [jaq_pkg::OP_W-1:0]   op_s1;
	logic [DATA_BITS-1:0]       value_s1;
	logic [jaq_pkg::DIST_W-1:0] dist_s1;
	logic                       hin_ok_s1;
	logic [HW-1:0]              free_s1;

	// chain wires
	logic [DATA_BITS-1:0] val_w   [CAPACITY];
	logic [HW-1:0]        hdl_w   [CAPACITY];
	logic [CAPACITY-1:0]  match_w;

	logic                 accept;
	logic                 exec_go;
	jaq_pkg::cell_ctl_t   ctl;
	logic [HW-1:0]        hin;
	logic [CAPACITY-1:0]  free_oh;
	logic [HW-1:0]        free_idx;
	logic [HW-1:0]        pos;
	logic [HW-1:0]        np;
	logic [PW-1:0]        pos_ext;
	logic [PW-1:0]        dist_ext;
	logic [DATA_BITS-1:0] moved_val;
	logic [HW-1:0]        moved_hdl;
	logic                 full;
	logic                 empty;
	logic                 unknown;
	logic [CW-1:0]        count_nx;

	// output register
	logic                          res_valid_q;
	logic [jaq_pkg::ST_W-1:0]      status_q;
	logic [jaq_pkg::VAL_W-1:0]     value_q;
	logic [jaq_pkg::HDL_W-1:0]     hout_q;
	logic [jaq_pkg::POS_W-1:0]     pos_q;
	logic [jaq_pkg::CNT_W-1:0]     cnt_q;

	logic [jaq_pkg::ST_W-1:0]      status_c;
	logic [jaq_pkg::VAL_W-1:0]     value_c;
	logic [jaq_pkg::HDL_W-1:0]     hout_c;
	logic [jaq_pkg::POS_W-1:0]     pos_c;

	assign cmd.ready = (state_q == S_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign exec_go   = (state_q == S_EXEC) && (!res_valid_q || res.ready);
	assign hin       = HW'(cmd.handle_in);

	// lowest free handle: isolate lowest clear bit, then encode
	always_comb begin
		free_oh  = ~used_q & (used_q + CAPACITY'(1));
		free_idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (free_oh[i]) free_idx = free_idx | HW'(i);
		end
	end

	// position and moved element from the one-hot match row
	always_comb begin
		pos       = '0;
		moved_val = '0;
		moved_hdl = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (match_w[i]) begin
				pos       = pos | HW'(i);
				moved_val = moved_val | val_w[i];
				moved_hdl = moved_hdl | hdl_w[i];
			end
		end
		pos_ext  = PW'(pos);
		dist_ext = PW'(dist_s1);
		np       = (pos_ext > dist_ext) ? HW'(pos_ext - dist_ext) : '0;
	end

	assign full    = (count_q == CAP_CNT);
	assign empty   = (count_q == '0);
	assign unknown = !hin_ok_s1 || !(|match_w);

	// result and next count
	always_comb begin
		status_c = jaq_pkg::ST_OK;
		value_c  = '0;
		hout_c   = '0;
		pos_c    = '0;
		count_nx = count_q;
		case (op_s1)
			jaq_pkg::OP_PUSH: begin
				if (full) begin
					status_c = jaq_pkg::ST_FULL;
				end else begin
					hout_c   = jaq_pkg::HDL_W'(free_s1);
					count_nx = count_q + CW'(1);
				end
			end
			jaq_pkg::OP_POP: begin
				if (empty) begin
					status_c = jaq_pkg::ST_EMPTY;
				end else begin
					value_c  = jaq_pkg::VAL_W'($signed(val_w[0]));
					count_nx = count_q - CW'(1);
				end
			end
			jaq_pkg::OP_QUERY: begin
				if (unknown) status_c = jaq_pkg::ST_UNKNOWN;
				else pos_c = jaq_pkg::POS_W'(pos);
			end
			jaq_pkg::OP_JUMP: begin
				if (unknown) status_c = jaq_pkg::ST_UNKNOWN;
				else pos_c = jaq_pkg::POS_W'(np);
			end
			default: status_c = jaq_pkg::ST_OK;
		endcase
	end

	// cell control
	always_comb begin
		ctl.load = accept;
		ctl.push = exec_go && (op_s1 == jaq_pkg::OP_PUSH) && !full;
		ctl.pop  = exec_go && (op_s1 == jaq_pkg::OP_POP) && !empty;
		ctl.jump = exec_go && (op_s1 == jaq_pkg::OP_JUMP) && !unknown;
	end

	// slot chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_BITS-1:0] pv, nv;
		logic [HW-1:0]        ph, nh;
		if (i == 0) begin : g_first
			assign pv = '0;
			assign ph = '0;
		end else begin : g_mid
			assign pv = val_w[i-1];
			assign ph = hdl_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign nv = '0;
			assign nh = '0;
		end else begin : g_inner
			assign nv = val_w[i+1];
			assign nh = hdl_w[i+1];
		end
		jaq_cell #(
			.DATA_BITS (DATA_BITS),
			.HW        (HW),
			.CW        (CW),
			.INDEX     (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.count     (count_q),
			.pos       (pos),
			.np        (np),
			.hin       (hin),
			.push_val  (value_s1),
			.push_hdl  (free_s1),
			.moved_val (moved_val),
			.moved_hdl (moved_hdl),
			.prev_val  (pv),
			.prev_hdl  (ph),
			.next_val  (nv),
			.next_hdl  (nh),
			.val       (val_w[i]),
			.hdl       (hdl_w[i]),
			.match     (match_w[i])
		);
	end

	// command capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= cmd.op;
			value_s1  <= DATA_BITS'($unsigned(cmd.push_value));
			dist_s1   <= cmd.jump_distance;
			hin_ok_s1 <= (32'(cmd.handle_in) < CAPACITY);
			free_s1   <= free_idx;
		end
	end

	// sequencer, count and handle bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			used_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (exec_go) begin
						state_q <= S_IDLE;
						count_q <= count_nx;
						if (ctl.push) used_q[free_s1] <= 1'b1;
						if (ctl.pop) used_q[hdl_w[0]] <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (exec_go) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (exec_go) begin
			status_q <= status_c;
			value_q  <= value_c;
			hout_q   <= hout_c;
			pos_q    <= pos_c;
			cnt_q    <= jaq_pkg::CNT_W'(count_nx);
		end
	end

	assign res.valid        = res_valid_q;
	assign res.status       = status_q;
	assign res.value_out    = value_q;
	assign res.handle_out   = hout_q;
	assign res.position_out = pos_q;
	assign res.count_out    = cnt_q;

endmodule

// File: hdl/jaq_cell.sv
// One queue slot: holds a value and its handle, trades with its neighbours.
module jaq_cell #(
	parameter int DATA_BITS = jaq_pkg::DATA_BITS_DEF,
	parameter int HW        = 6,
	parameter int CW        = 7,
	parameter int INDEX     = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  jaq_pkg::cell_ctl_t    ctl,
	input  logic [CW-1:0]         count,
	input  logic [HW-1:0]         pos,
	input  logic [HW-1:0]         np,
	input  logic [HW-1:0]         hin,
	input  logic [DATA_BITS-1:0]  push_val,
	input  logic [HW-1:0]         push_hdl,
	input  logic [DATA_BITS-1:0]  moved_val,
	input  logic [HW-1:0]         moved_hdl,
	input  logic [DATA_BITS-1:0]  prev_val,
	input  logic [HW-1:0]         prev_hdl,
	input  logic [DATA_BITS-1:0]  next_val,
	input  logic [HW-1:0]         next_hdl,
	output logic [DATA_BITS-1:0]  val,
	output logic [HW-1:0]         hdl,
	output logic                  match
);

	localparam logic [CW-1:0] IDX_C = CW'(INDEX);
	localparam logic [HW-1:0] IDX_H = HW'(INDEX);

	logic [DATA_BITS-1:0] val_q;
	logic [HW-1:0]        hdl_q;
	logic                 match_q;

	// slot contents: push at tail, shift on pop, rotate on jump
	always_ff @(posedge clk) begin
		if (ctl.push && count == IDX_C) begin
			val_q <= push_val;
			hdl_q <= push_hdl;
		end else if (ctl.pop) begin
			val_q <= next_val;
			hdl_q <= next_hdl;
		end else if (ctl.jump) begin
			if (IDX_H == np) begin
				val_q <= moved_val;
				hdl_q <= moved_hdl;
			end else if (IDX_H > np && IDX_H <= pos) begin
				val_q <= prev_val;
				hdl_q <= prev_hdl;
			end
		end
	end

	// handle match, only among occupied slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.load) begin
			match_q <= (IDX_C < count) && (hdl_q == hin);
		end
	end

	assign val   = val_q;
	assign hdl   = hdl_q;
	assign match = match_q;

endmodule

// File: hdl/jaq_checker.sv
`include "jump_ahead_queue_defines.svh"

// Port-level checks of the queue
module jaq_checker #(
	parameter int CAPACITY = jaq_pkg::CAPACITY_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cmd_valid,
	input logic                         cmd_ready,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic [jaq_pkg::ST_W-1:0]     res_status,
	input logic [jaq_pkg::VAL_W-1:0]    res_value,
	input logic [jaq_pkg::CNT_W-1:0]    res_count
);

	// a stalled result holds
	`JAQ_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_status) && $stable(res_count))

	// a command keeps the block busy in the following cycle
	`JAQ_ASSERT_NEXT(a_busy_after_cmd, cmd_valid && cmd_ready, !cmd_ready)

	// full is only reported with the queue at capacity
	`JAQ_ASSERT_NOW(a_full_count, res_valid && res_status == jaq_pkg::ST_FULL, res_count == jaq_pkg::CNT_W'(CAPACITY))

	// empty is only reported with nothing stored, and returns no value
	`JAQ_ASSERT_NOW(a_empty_count, res_valid && res_status == jaq_pkg::ST_EMPTY, res_count == '0 && res_value == '0)

endmodule

bind jump_ahead_queue jaq_checker #(.CAPACITY(CAPACITY)) u_jaq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_valid  (cmd.valid),
	.cmd_ready  (cmd.ready),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.res_status (res.status),
	.res_value  (res.value_out),
	.res_count  (res.count_out)
);

// File: test/tb_top.sv
module tb_top;

	localparam int CAP = jaq_pkg::CAPACITY_DEF;

	// One command as it is offered on the command channel
	typedef struct packed {
		logic [jaq_pkg::OP_W-1:0]   op;
		logic [jaq_pkg::VAL_W-1:0]  value;
		logic [jaq_pkg::HDL_W-1:0]  handle;
		logic [jaq_pkg::DIST_W-1:0] jump_dist;
	} queue_cmd_t;

	// One reply as it should appear on the result channel
	typedef struct packed {
		logic [jaq_pkg::ST_W-1:0]  status;
		logic [jaq_pkg::VAL_W-1:0] value;
		logic [jaq_pkg::HDL_W-1:0] handle;
		logic [jaq_pkg::POS_W-1:0] pos;
		logic [jaq_pkg::CNT_W-1:0] count;
	} queue_reply_t;

	// Ordered storage, head at index 0
	typedef struct packed {
		logic [CAP-1:0][jaq_pkg::VAL_W-1:0] vals;
		logic [CAP-1:0][jaq_pkg::HDL_W-1:0] hdls;
		logic [CAP-1:0]                     used;
		logic [jaq_pkg::CNT_W-1:0]          cnt;
	} queue_state_t;

	logic clk;
	logic arst_n;

	jaq_cmd_if cmd_ch ();
	jaq_res_if res_ch ();

	jump_ahead_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	queue_cmd_t   cmd_backlog[$];
	queue_reply_t queue_replies[$];
	queue_state_t live_st;
	queue_state_t gen_st;
	queue_reply_t got_reply;
	queue_cmd_t   next_cmd;
	int           total_cmds;
	int           n_taken;
	int           errors;

	// Apply one command to a queue image and return the reply it gives
	function automatic queue_reply_t queue_apply(inout queue_state_t st, input queue_cmd_t c);
		queue_reply_t r;
		int           pos;
		int           np;
		int           h;
		int           i;
		logic [jaq_pkg::VAL_W-1:0] v;
		logic [jaq_pkg::HDL_W-1:0] hh;
		r = '0;
		pos = -1;
		case (c.op)
			jaq_pkg::OP_PUSH: begin
				h = 0;
				while (h < CAP && st.used[h])
					h++;
				if (st.cnt >= CAP || h >= CAP) begin
					r.status = jaq_pkg::ST_FULL;
				end else begin
					st.used[h] = 1'b1;
					st.vals[st.cnt] = c.value;
					st.hdls[st.cnt] = h[jaq_pkg::HDL_W-1:0];
					st.cnt = st.cnt + 1'b1;
					r.handle = h[jaq_pkg::HDL_W-1:0];
				end
			end
			jaq_pkg::OP_POP: begin
				if (st.cnt == 0) begin
					r.status = jaq_pkg::ST_EMPTY;
				end else begin
					r.value = st.vals[0];
					st.used[st.hdls[0]] = 1'b0;
					for (i = 1; i < st.cnt; i++) begin
						st.vals[i-1] = st.vals[i];
						st.hdls[i-1] = st.hdls[i];
					end
					st.cnt = st.cnt - 1'b1;
				end
			end
			default: begin
				if (st.used[c.handle])
					for (i = 0; i < st.cnt; i++)
						if (st.hdls[i] == c.handle)
							pos = i;
				if (pos < 0) begin
					r.status = jaq_pkg::ST_UNKNOWN;
				end else if (c.op == jaq_pkg::OP_QUERY) begin
					r.pos = pos[jaq_pkg::POS_W-1:0];
				end else begin
					np = (pos > int'(c.jump_dist)) ? pos - int'(c.jump_dist) : 0;
					v = st.vals[pos];
					hh = st.hdls[pos];
					for (i = pos; i > np; i--) begin
						st.vals[i] = st.vals[i-1];
						st.hdls[i] = st.hdls[i-1];
					end
					st.vals[np] = v;
					st.hdls[np] = hh;
					r.pos = np[jaq_pkg::POS_W-1:0];
				end
			end
		endcase
		r.count = st.cnt;
		return r;
	endfunction

	// Queue a command and track its effect so later handles can be aimed
	task automatic add_cmd(input logic [jaq_pkg::OP_W-1:0] op,
		input logic [jaq_pkg::VAL_W-1:0] value,
		input logic [jaq_pkg::HDL_W-1:0] handle,
		input logic [jaq_pkg::DIST_W-1:0] jump_dist);
		queue_cmd_t c;
		c.op = op;
		c.value = value;
		c.handle = handle;
		c.jump_dist = jump_dist;
		cmd_backlog.insert(cmd_backlog.size(), c);
		void'(queue_apply(gen_st, c));
	endtask

	function automatic logic [jaq_pkg::VAL_W-1:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Mostly a live handle, sometimes any handle at all
	function automatic logic [jaq_pkg::HDL_W-1:0] pick_handle();
		if (gen_st.cnt != 0 && $urandom_range(0, 99) < 85)
			return gen_st.hdls[$urandom_range(0, gen_st.cnt - 1)];
		return jaq_pkg::HDL_W'($urandom_range(0, CAP - 1));
	endfunction

	function automatic logic [jaq_pkg::DIST_W-1:0] pick_dist();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 7'd64;
			2: return jaq_pkg::DIST_W'($urandom_range(0, 64));
			default: return jaq_pkg::DIST_W'($urandom_range(0,
				(gen_st.cnt > 1) ? gen_st.cnt - 1 : 1));
		endcase
	endfunction

	// Idle share of each side in the current third of the run
	function automatic bit side_idles(input bit is_sender);
		int third;
		int pct;
		third = (total_cmds > 0) ? (n_taken * 3) / total_cmds : 2;
		case (third)
			0: pct = is_sender ? 25 : 74;
			1: pct = is_sender ? 74 : 25;
			default: pct = 0;
		endcase
		return $urandom_range(0, 99) < pct;
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Run limit
	initial begin
		#2000000;
		$display("tb_top: done, errors");
		$finish;
	end

	// Command driver: holds an offered command until its transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				queue_replies.insert(queue_replies.size(),
					queue_apply(live_st, cmd_backlog.pop_front()));
				n_taken++;
			end
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (cmd_backlog.size() != 0 && !side_idles(1'b1)) begin
					next_cmd = cmd_backlog[0];
					cmd_ch.valid <= 1'b1;
					cmd_ch.op <= next_cmd.op;
					cmd_ch.push_value <= next_cmd.value;
					cmd_ch.handle_in <= next_cmd.handle;
					cmd_ch.jump_distance <= next_cmd.jump_dist;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (queue_replies.size() == 0) begin
					$error("result transfer with no command outstanding");
					errors++;
				end else begin
					got_reply = queue_replies.pop_front();
					if (res_ch.status !== got_reply.status) begin
						$error("status: expected %0d, got %0d", got_reply.status, res_ch.status);
						errors++;
					end
					if (res_ch.value_out !== got_reply.value) begin
						$error("value_out: expected %h, got %h", got_reply.value,
							res_ch.value_out);
						errors++;
					end
					if (res_ch.handle_out !== got_reply.handle) begin
						$error("handle_out: expected %0d, got %0d", got_reply.handle,
							res_ch.handle_out);
						errors++;
					end
					if (res_ch.position_out !== got_reply.pos) begin
						$error("position_out: expected %0d, got %0d", got_reply.pos,
							res_ch.position_out);
						errors++;
					end
					if (res_ch.count_out !== got_reply.count) begin
						$error("count_out: expected %0d, got %0d", got_reply.count,
							res_ch.count_out);
						errors++;
					end
				end
			end
			res_ch.ready <= !side_idles(1'b0);
		end
	end

	// Stimulus, reset and end of run
	initial begin
		int n;
		int k;
		int roll;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.op = jaq_pkg::OP_PUSH;
		cmd_ch.push_value = '0;
		cmd_ch.handle_in = '0;
		cmd_ch.jump_distance = '0;
		res_ch.ready = 1'b0;
		live_st = '0;
		gen_st = '0;
		n_taken = 0;
		errors = 0;

		// Directed: empty queue, extreme values, each op and the clamping cases
		add_cmd(jaq_pkg::OP_POP, '0, '0, '0);
		add_cmd(jaq_pkg::OP_QUERY, '0, 6'd0, '0);
		add_cmd(jaq_pkg::OP_JUMP, '0, 6'd63, 7'd64);
		add_cmd(jaq_pkg::OP_PUSH, 32'h7FFF_FFFF, '0, '0);
		add_cmd(jaq_pkg::OP_PUSH, 32'h8000_0000, '0, '0);
		add_cmd(jaq_pkg::OP_PUSH, 32'h0000_0000, '0, '0);
		add_cmd(jaq_pkg::OP_PUSH, 32'hFFFF_FFFF, '0, '0);
		add_cmd(jaq_pkg::OP_PUSH, 32'h5555_5555, '0, '0);
		add_cmd(jaq_pkg::OP_PUSH, 32'hAAAA_AAAA, '0, '0);
		add_cmd(jaq_pkg::OP_QUERY, '0, 6'd5, '0);
		add_cmd(jaq_pkg::OP_QUERY, '0, 6'd63, '0);
		add_cmd(jaq_pkg::OP_JUMP, '0, 6'd5, 7'd0);
		add_cmd(jaq_pkg::OP_JUMP, '0, 6'd4, 7'd1);
		add_cmd(jaq_pkg::OP_JUMP, '0, 6'd3, 7'd64);
		add_cmd(jaq_pkg::OP_JUMP, '0, 6'd0, 7'd2);
		add_cmd(jaq_pkg::OP_QUERY, '0, 6'd0, '0);
		add_cmd(jaq_pkg::OP_POP, '0, '0, '0);
		add_cmd(jaq_pkg::OP_QUERY, '0, 6'd3, '0);
		add_cmd(jaq_pkg::OP_PUSH, 32'h1234_5678, '0, '0);
		add_cmd(jaq_pkg::OP_JUMP, '0, 6'd5, 7'd63);
		while (gen_st.cnt != 0)
			add_cmd(jaq_pkg::OP_POP, '0, '0, '0);
		add_cmd(jaq_pkg::OP_POP, '0, '0, '0);

		// Random: fill and drain bursts between mixed runs of live-handle traffic
		while (cmd_backlog.size() < 525) begin
			roll = $urandom_range(0, 9);
			if (roll == 0) begin
				n = CAP - gen_st.cnt + $urandom_range(1, 2);
				for (k = 0; k < n; k++)
					add_cmd(jaq_pkg::OP_PUSH, rand_word(), jaq_pkg::HDL_W'($urandom),
						jaq_pkg::DIST_W'($urandom));
			end else if (roll == 1) begin
				n = gen_st.cnt + $urandom_range(1, 2);
				for (k = 0; k < n; k++)
					add_cmd(jaq_pkg::OP_POP, $urandom, jaq_pkg::HDL_W'($urandom),
						jaq_pkg::DIST_W'($urandom));
			end else begin
				n = $urandom_range(10, 30);
				for (k = 0; k < n; k++) begin
					roll = $urandom_range(0, 99);
					if (roll < 30)
						add_cmd(jaq_pkg::OP_PUSH, rand_word(), jaq_pkg::HDL_W'($urandom),
							jaq_pkg::DIST_W'($urandom));
					else if (roll < 50)
						add_cmd(jaq_pkg::OP_POP, $urandom, jaq_pkg::HDL_W'($urandom),
							jaq_pkg::DIST_W'($urandom));
					else if (roll < 75)
						add_cmd(jaq_pkg::OP_QUERY, $urandom, pick_handle(),
							jaq_pkg::DIST_W'($urandom_range(0, 64)));
					else
						add_cmd(jaq_pkg::OP_JUMP, $urandom, pick_handle(), pick_dist());
				end
			end
		end
		total_cmds = cmd_backlog.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: every command taken and every reply seen, then a short tail
		while (cmd_backlog.size() != 0 || queue_replies.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (errors == 0 && queue_replies.size() == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
